// File: hw/rtl/dlcf_pkg.sv
// ----------------------------------------------------------------------------
// dlcf_pkg
// Shared types and codes of the linear spring contact force block: the
// request and response payloads, the register set and its addresses.
// ----------------------------------------------------------------------------
package dlcf_pkg;

   localparam int FIELD_BITS = 63;
   localparam int ADDR_BITS  = 5;

   typedef struct packed {
      logic                  is_new;
      logic [15:0]           group_masks;
      logic signed [31:0]    penetration;
      logic [FIELD_BITS-1:0] contact_normal;
      logic [FIELD_BITS-1:0] arm_a;
      logic [FIELD_BITS-1:0] arm_b;
      logic [FIELD_BITS-1:0] velocity_a;
      logic [FIELD_BITS-1:0] velocity_b;
      logic [FIELD_BITS-1:0] spin_a;
      logic [FIELD_BITS-1:0] spin_b;
      logic [FIELD_BITS-1:0] old_shear;
      logic [FIELD_BITS-1:0] old_normal;
   } req_type;

   typedef struct packed {
      logic                  applies;
      logic [FIELD_BITS-1:0] contact_force;
      logic [FIELD_BITS-1:0] moment_a;
      logic [FIELD_BITS-1:0] moment_b;
      logic [FIELD_BITS-1:0] new_shear;
   } rsp_type;

   typedef struct packed {
      logic [15:0] time_step;
      logic [31:0] normal_stiffness;
      logic [31:0] shear_stiffness;
      logic [7:0]  first_group_mask;
      logic [7:0]  second_group_mask;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_TIME_STEP        = 3'd0,
      REG_NORMAL_STIFFNESS = 3'd1,
      REG_SHEAR_STIFFNESS  = 3'd2,
      REG_FIRST_MASK       = 3'd3,
      REG_SECOND_MASK      = 3'd4
   } reg_index_type;

endpackage

// File: hw/rtl/dem_linear_contact_force.sv
// ----------------------------------------------------------------------------
// dem_linear_contact_force
// Linear spring contact law for one contact per item: normal spring force,
// shear force rotated for tilt and twist plus the incremental shear spring,
// total force and both body moments, all in saturated Q.12 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one contact per item, taken at an edge with req_valid high
//   and req_stall low. rsp_* returns one result per item, in order; applies
//   is low for a pair that does not match the group masks, and then the
//   kept shear force comes back unchanged.
//   A result shows on rsp_valid once its item has passed the input register
//   and six arithmetic stages (one multiplier layer each), the last of which
//   is the output register.
//   Throughput: one item per cycle while rsp_stall stays low.
//   A stalled result holds in the output register; stages behind it keep
//   filling their empty slots, so req_stall rises only once every stage
//   holds an item.
//   Reset (synchronous) empties the pipeline, loads the register defaults.
//   Write registers over the APB-style port only while idle; not enforced.
// ----------------------------------------------------------------------------
module dem_linear_contact_force #(
   parameter int COMPONENT_BITS = 21,
   parameter int MASK_BITS      = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dlcf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dlcf_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dlcf_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import dlcf_pkg::*;

   localparam int C  = COMPONENT_BITS;
   localparam int VW = 3 * C;
   localparam int XR = 2 * C - 11;
   localparam int DW = C + 1;
   localparam logic signed [63:0] CMAX = (64'sd1 <<< (C - 1)) - 64'sd1;
   localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;
   localparam logic signed [44:0] KN_CLAMP = 45'sd1 <<< 40;
   localparam logic [31:0] MMASK = 32'((64'd1 << MASK_BITS) - 64'd1);

   function automatic logic signed [C-1:0] comp(input logic [VW-1:0] v, input int idx);
      return v[idx*C +: C];
   endfunction

   function automatic logic [C-1:0] sat(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = x;
      if (x > CMAX) y = CMAX;
      if (x < CMIN) y = CMIN;
      return y[C-1:0];
   endfunction

   cfg_type cfg;

   dlcf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // stage valids and per-stage advance, a stage moves when empty or drained
   logic [7:1] valid_ff;
   logic [7:1] adv;

   always_comb begin
      adv[7] = !valid_ff[7] || !rsp_stall;
      for (int k = 6; k >= 1; k--) adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) valid_ff[1] <= req_valid;
         for (int k = 2; k <= 7; k++) if (adv[k]) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // ---------------- stage 1: capture and pair match ----------------
   logic [31:0] gm32, ga, gb, m1, m2;
   logic        s1_match_in;

   assign gm32 = {16'd0, req_data.group_masks};
   assign ga   = gm32 & MMASK;
   assign gb   = (gm32 >> MASK_BITS) & MMASK;
   assign m1   = {24'd0, cfg.first_group_mask};
   assign m2   = {24'd0, cfg.second_group_mask};
   assign s1_match_in = (((ga & m1) != 0) && ((gb & m2) != 0)) ||
                        (((ga & m2) != 0) && ((gb & m1) != 0));

   logic                  s1_match_ff;
   logic signed [31:0]    s1_un_ff;
   logic [VW-1:0]         s1_n_ff, s1_ca_ff, s1_cb_ff, s1_va_ff, s1_vb_ff;
   logic [VW-1:0]         s1_wa_ff, s1_wb_ff, s1_sh_ff, s1_pn_ff;
   logic [FIELD_BITS-1:0] s1_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_match_ff <= s1_match_in;
         s1_un_ff    <= req_data.penetration;
         s1_n_ff     <= req_data.contact_normal[VW-1:0];
         s1_ca_ff    <= req_data.arm_a[VW-1:0];
         s1_cb_ff    <= req_data.arm_b[VW-1:0];
         s1_va_ff    <= req_data.velocity_a[VW-1:0];
         s1_vb_ff    <= req_data.velocity_b[VW-1:0];
         s1_wa_ff    <= req_data.spin_a[VW-1:0];
         s1_wb_ff    <= req_data.spin_b[VW-1:0];
         s1_sh_ff    <= req_data.is_new ? '0 : req_data.old_shear[VW-1:0];
         s1_pn_ff    <= req_data.old_normal[VW-1:0];
         s1_raw_ff   <= req_data.old_shear;
      end
   end

   // ---------------- stage 2: normal scalar, tilt axis, spin dot, velocity
   logic [3*XR-1:0] tilt_r, xb_r, xa_r;

   dlcf_cross #(.COMPONENT_BITS(C)) u_tilt (.a_vec(s1_pn_ff), .b_vec(s1_n_ff), .r_vec(tilt_r));
   dlcf_cross #(.COMPONENT_BITS(C)) u_velb (.a_vec(s1_wb_ff), .b_vec(s1_cb_ff), .r_vec(xb_r));
   dlcf_cross #(.COMPONENT_BITS(C)) u_vela (.a_vec(s1_wa_ff), .b_vec(s1_ca_ff), .r_vec(xa_r));

   logic signed [41:0]    s2_s_in;
   logic [VW-1:0]         s2_t_in, s2_rv_in;
   logic signed [2*C+2:0] s2_dotw_in;

   always_comb begin
      logic signed [64:0]  knp;
      logic signed [44:0]  ksh;
      logic signed [C:0]   ws;
      logic signed [2*C:0] pr;
      knp = $signed({1'b0, cfg.normal_stiffness}) * s1_un_ff;
      ksh = knp[64:20];
      if (ksh > KN_CLAMP)       s2_s_in = 42'(KN_CLAMP);
      else if (ksh < -KN_CLAMP) s2_s_in = 42'(-KN_CLAMP);
      else                      s2_s_in = 42'(ksh);
      s2_dotw_in = '0;
      for (int i = 0; i < 3; i++) begin
         s2_t_in[i*C +: C] = sat(64'($signed(tilt_r[i*XR +: XR])));
         ws = comp(s1_wa_ff, i) + comp(s1_wb_ff, i);
         pr = comp(s1_n_ff, i) * ws;
         s2_dotw_in = s2_dotw_in + pr;
         s2_rv_in[i*C +: C] = sat(64'(comp(s1_vb_ff, i)) + 64'($signed(xb_r[i*XR +: XR]))
                                  - 64'(comp(s1_va_ff, i)) - 64'($signed(xa_r[i*XR +: XR])));
      end
   end

   logic                  s2_match_ff;
   logic signed [41:0]    s2_s_ff;
   logic signed [2*C+2:0] s2_dotw_ff;
   logic [VW-1:0]         s2_n_ff, s2_ca_ff, s2_cb_ff, s2_sh_ff, s2_t_ff, s2_rv_ff;
   logic [FIELD_BITS-1:0] s2_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_match_ff <= s1_match_ff;
         s2_s_ff     <= s2_s_in;
         s2_dotw_ff  <= s2_dotw_in;
         s2_n_ff     <= s1_n_ff;
         s2_ca_ff    <= s1_ca_ff;
         s2_cb_ff    <= s1_cb_ff;
         s2_sh_ff    <= s1_sh_ff;
         s2_t_ff     <= s2_t_in;
         s2_rv_ff    <= s2_rv_in;
         s2_raw_ff   <= s1_raw_ff;
      end
   end

   // ---------------- stage 3: normal force, tilt rotation, twist angle, vn
   logic [3*XR-1:0] rot1_r;

   dlcf_cross #(.COMPONENT_BITS(C)) u_rot1 (.a_vec(s2_sh_ff), .b_vec(s2_t_ff), .r_vec(rot1_r));

   logic [VW-1:0] s3_fn_in, s3_sh_in;
   logic [C-1:0]  s3_ang_in, s3_vn_in;

   always_comb begin
      logic signed [41+C:0]  fp;
      logic signed [2*C+19:0] ap;
      logic signed [2*C-1:0] pr;
      logic signed [2*C+2:0] acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         fp = s2_s_ff * comp(s2_n_ff, i);
         s3_fn_in[i*C +: C] = sat(64'(fp >>> 12));
         s3_sh_in[i*C +: C] = sat(64'(comp(s2_sh_ff, i)) - 64'($signed(rot1_r[i*XR +: XR])));
         pr = comp(s2_n_ff, i) * comp(s2_rv_ff, i);
         acc = acc + pr;
      end
      ap = s2_dotw_ff * $signed({1'b0, cfg.time_step});
      s3_ang_in = sat(64'(ap >>> 29));
      s3_vn_in  = sat(64'(acc >>> 12));
   end

   logic                  s3_match_ff;
   logic [C-1:0]          s3_ang_ff, s3_vn_ff;
   logic [VW-1:0]         s3_n_ff, s3_ca_ff, s3_cb_ff, s3_fn_ff, s3_sh_ff, s3_rv_ff;
   logic [FIELD_BITS-1:0] s3_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_match_ff <= s2_match_ff;
         s3_ang_ff   <= s3_ang_in;
         s3_vn_ff    <= s3_vn_in;
         s3_n_ff     <= s2_n_ff;
         s3_ca_ff    <= s2_ca_ff;
         s3_cb_ff    <= s2_cb_ff;
         s3_fn_ff    <= s3_fn_in;
         s3_sh_ff    <= s3_sh_in;
         s3_rv_ff    <= s2_rv_ff;
         s3_raw_ff   <= s2_raw_ff;
      end
   end

   // ---------------- stage 4: twist axis and shear velocity ----------------
   logic [VW-1:0] s4_t_in, s4_sv_in;

   always_comb begin
      logic signed [2*C-1:0] p;
      logic signed [2*C-1:0] q;
      for (int i = 0; i < 3; i++) begin
         p = $signed(s3_ang_ff) * comp(s3_n_ff, i);
         q = $signed(s3_vn_ff) * comp(s3_n_ff, i);
         s4_t_in[i*C +: C]  = sat(64'(p >>> 12));
         s4_sv_in[i*C +: C] = sat(64'(comp(s3_rv_ff, i)) - 64'(q >>> 12));
      end
   end

   logic                  s4_match_ff;
   logic [VW-1:0]         s4_ca_ff, s4_cb_ff, s4_fn_ff, s4_sh_ff, s4_t_ff, s4_sv_ff;
   logic [FIELD_BITS-1:0] s4_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_match_ff <= s3_match_ff;
         s4_ca_ff    <= s3_ca_ff;
         s4_cb_ff    <= s3_cb_ff;
         s4_fn_ff    <= s3_fn_ff;
         s4_sh_ff    <= s3_sh_ff;
         s4_t_ff     <= s4_t_in;
         s4_sv_ff    <= s4_sv_in;
         s4_raw_ff   <= s3_raw_ff;
      end
   end

   // ---------------- stage 5: twist rotation and shear displacement --------
   logic [3*XR-1:0] rot2_r;

   dlcf_cross #(.COMPONENT_BITS(C)) u_rot2 (.a_vec(s4_sh_ff), .b_vec(s4_t_ff), .r_vec(rot2_r));

   logic [VW-1:0]   s5_sh_in;
   logic [3*DW-1:0] s5_disp_in;

   always_comb begin
      logic signed [C+16:0] p;
      for (int i = 0; i < 3; i++) begin
         s5_sh_in[i*C +: C] = sat(64'(comp(s4_sh_ff, i)) - 64'($signed(rot2_r[i*XR +: XR])));
         p = comp(s4_sv_ff, i) * $signed({1'b0, cfg.time_step});
         s5_disp_in[i*DW +: DW] = p[C+16:16];
      end
   end

   logic                  s5_match_ff;
   logic [VW-1:0]         s5_ca_ff, s5_cb_ff, s5_fn_ff, s5_sh_ff;
   logic [3*DW-1:0]       s5_disp_ff;
   logic [FIELD_BITS-1:0] s5_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_match_ff <= s4_match_ff;
         s5_ca_ff    <= s4_ca_ff;
         s5_cb_ff    <= s4_cb_ff;
         s5_fn_ff    <= s4_fn_ff;
         s5_sh_ff    <= s5_sh_in;
         s5_disp_ff  <= s5_disp_in;
         s5_raw_ff   <= s4_raw_ff;
      end
   end

   // ---------------- stage 6: shear spring and total force ----------------
   logic [VW-1:0] s6_sh_in, s6_f_in;

   always_comb begin
      logic signed [C+33:0] p;
      logic [C-1:0]         shn;
      for (int i = 0; i < 3; i++) begin
         p   = $signed({1'b0, cfg.shear_stiffness}) * $signed(s5_disp_ff[i*DW +: DW]);
         shn = sat(64'(comp(s5_sh_ff, i)) - 64'(p >>> 16));
         s6_sh_in[i*C +: C] = shn;
         s6_f_in[i*C +: C]  = sat(64'(comp(s5_fn_ff, i)) + 64'($signed(shn)));
      end
   end

   logic                  s6_match_ff;
   logic [VW-1:0]         s6_ca_ff, s6_cb_ff, s6_f_ff, s6_sh_ff;
   logic [FIELD_BITS-1:0] s6_raw_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_match_ff <= s5_match_ff;
         s6_ca_ff    <= s5_ca_ff;
         s6_cb_ff    <= s5_cb_ff;
         s6_f_ff     <= s6_f_in;
         s6_sh_ff    <= s6_sh_in;
         s6_raw_ff   <= s5_raw_ff;
      end
   end

   // ---------------- stage 7: moments and output register ----------------
   logic [3*XR-1:0] ma_r, mb_r;

   dlcf_cross #(.COMPONENT_BITS(C)) u_mom_a (.a_vec(s6_f_ff), .b_vec(s6_ca_ff), .r_vec(ma_r));
   dlcf_cross #(.COMPONENT_BITS(C)) u_mom_b (.a_vec(s6_cb_ff), .b_vec(s6_f_ff), .r_vec(mb_r));

   rsp_type       rsp_in;
   rsp_type       rsp_ff;
   logic [VW-1:0] ma_v, mb_v;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ma_v[i*C +: C] = sat(64'($signed(ma_r[i*XR +: XR])));
         mb_v[i*C +: C] = sat(64'($signed(mb_r[i*XR +: XR])));
      end
      rsp_in.applies = s6_match_ff;
      if (s6_match_ff) begin
         rsp_in.contact_force = FIELD_BITS'(s6_f_ff);
         rsp_in.moment_a      = FIELD_BITS'(ma_v);
         rsp_in.moment_b      = FIELD_BITS'(mb_v);
         rsp_in.new_shear     = FIELD_BITS'(s6_sh_ff);
      end else begin
         // unmatched pair: no force, kept shear passes through untouched
         rsp_in.contact_force = '0;
         rsp_in.moment_a      = '0;
         rsp_in.moment_b      = '0;
         rsp_in.new_shear     = s6_raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hw/rtl/dlcf_csr.sv
// ----------------------------------------------------------------------------
// dlcf_csr
// Register file of the contact force block behind an APB-style port.
// ----------------------------------------------------------------------------
module dlcf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dlcf_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output dlcf_pkg::cfg_type              cfg
);
   import dlcf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;

   assign index  = reg_index_type'(paddr[ADDR_BITS-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (index)
            REG_TIME_STEP:        cfg_in.time_step         = pwdata[15:0];
            REG_NORMAL_STIFFNESS: cfg_in.normal_stiffness  = pwdata;
            REG_SHEAR_STIFFNESS:  cfg_in.shear_stiffness   = pwdata;
            REG_FIRST_MASK:       cfg_in.first_group_mask  = pwdata[7:0];
            REG_SECOND_MASK:      cfg_in.second_group_mask = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step         <= 16'd16;
         cfg_ff.normal_stiffness  <= 32'd65536;
         cfg_ff.shear_stiffness   <= 32'd65536;
         cfg_ff.first_group_mask  <= 8'd1;
         cfg_ff.second_group_mask <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_TIME_STEP:        prdata = {16'd0, cfg_ff.time_step};
         REG_NORMAL_STIFFNESS: prdata = cfg_ff.normal_stiffness;
         REG_SHEAR_STIFFNESS:  prdata = cfg_ff.shear_stiffness;
         REG_FIRST_MASK:       prdata = {24'd0, cfg_ff.first_group_mask};
         REG_SECOND_MASK:      prdata = {24'd0, cfg_ff.second_group_mask};
         default:              prdata = 32'd0;
      endcase
   end

endmodule

// File: hw/rtl/dlcf_cross.sv
// ----------------------------------------------------------------------------
// dlcf_cross
// Fixed point cross product of two packed vectors, each component
// floor((a x b) / 2^12), left unsaturated.
// ----------------------------------------------------------------------------
module dlcf_cross #(
   parameter int COMPONENT_BITS = 21
) (
   input  logic [3*COMPONENT_BITS-1:0]      a_vec,
   input  logic [3*COMPONENT_BITS-1:0]      b_vec,
   output logic [3*(2*COMPONENT_BITS-11)-1:0] r_vec
);
   localparam int C  = COMPONENT_BITS;
   localparam int XR = 2 * C - 11;

   function automatic logic [XR-1:0] term(input logic [C-1:0] a1, input logic [C-1:0] b2,
                                          input logic [C-1:0] a2, input logic [C-1:0] b1);
      logic signed [2*C-1:0] p;
      logic signed [2*C-1:0] q;
      logic signed [2*C:0]   d;
      p = $signed(a1) * $signed(b2);
      q = $signed(a2) * $signed(b1);
      d = p - q;
      return d[2*C:12];
   endfunction

   logic [C-1:0] ax, ay, az, bx, by, bz;

   assign ax = a_vec[C-1:0];
   assign ay = a_vec[2*C-1:C];
   assign az = a_vec[3*C-1:2*C];
   assign bx = b_vec[C-1:0];
   assign by = b_vec[2*C-1:C];
   assign bz = b_vec[3*C-1:2*C];

   assign r_vec = {term(ax, by, ay, bx), term(az, bx, ax, bz), term(ay, bz, az, by)};

endmodule
